/* hw/rtl/chimpn_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, record flag codes and the leading-zero code table
// of the stream decoder. No dependencies.
package chimpn_pkg;

   localparam int HISTORY_LOG2_DEFAULT = 7;
   localparam int WORD_BITS_DEFAULT    = 32;

   // bit buffer: four 64-bit words, count spans 0..256
   localparam int BUF_BITS = 256;
   localparam int CNT_W    = 9;
   localparam int MAX_RECORDS = 6;

   localparam logic [63:0] END_MARK = 64'h7ff8_0000_0000_0000;

   localparam logic [1:0] FLAG_COPY   = 2'd0;
   localparam logic [1:0] FLAG_REF    = 2'd1;
   localparam logic [1:0] FLAG_REUSE  = 2'd2;
   localparam logic [1:0] FLAG_NEWLZ  = 2'd3;

   function automatic logic [4:0] lz_decode(input logic [2:0] code);
      logic [4:0] lz;
      case (code)
         3'd0:    lz = 5'd0;
         3'd1:    lz = 5'd8;
         3'd2:    lz = 5'd12;
         3'd3:    lz = 5'd16;
         3'd4:    lz = 5'd18;
         3'd5:    lz = 5'd20;
         3'd6:    lz = 5'd22;
         default: lz = 5'd24;
      endcase
      return lz;
   endfunction

endpackage

/* hw/rtl/chimpn_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chimpn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/chimpn_word_queue.sv */
`timescale 1ns / 1ps
// Front end: accepts stream words and holds them in a two-entry queue
// for the decode core. Depends on chimpn_pkg.
module chimpn_word_queue import chimpn_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_stream_word,
   output logic                 q_valid,
   output logic [WORD_BITS-1:0] q_word,
   input  logic                 q_pop
);

   logic [WORD_BITS-1:0] slot_ff [2];
   logic [WORD_BITS-1:0] slot_in [2];
   logic [1:0] fill_ff, fill_in;
   logic push;

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_word    = slot_ff[0];

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (q_pop && q_valid) begin
         slot_in[0] = slot_ff[1];
         fill_in    = fill_in - 2'd1;
      end
      if (push) begin
         slot_in[fill_in[0]] = req_stream_word;
         fill_in = fill_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_valid) |-> 1'b0)
      else $error("pop from empty word queue");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd2 && !q_pop) |=> (fill_ff == 2'd2))
      else $error("full word queue lost an entry");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff != 2'd3))
      else $error("word queue overfilled");

endmodule

/* hw/rtl/chimpn_decode_core.sv */
`timescale 1ns / 1ps
// Back end: bit buffer, record decoder, history ring and result register.
// Depends on chimpn_pkg and chimpn_ram.
module chimpn_decode_core import chimpn_pkg::*; #(
   parameter int HISTORY_LOG2 = HISTORY_LOG2_DEFAULT,
   parameter int WORD_BITS    = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  logic [WORD_BITS-1:0] q_word,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_value_bits,
   output logic                 rsp_end_of_stream,
   output logic                 rsp_last
);

   localparam int DEPTH = 1 << HISTORY_LOG2;
   localparam int H     = HISTORY_LOG2;
   localparam int TOP   = BUF_BITS - 1;

   typedef enum logic [1:0] {S_IDLE, S_HDR, S_EXEC, S_FLUSH} state_type;
   typedef enum logic [2:0] {K_RAW, K_COPY, K_REF, K_REUSE, K_NEWLZ} kind_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   logic [BUF_BITS-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [H-1:0]        rp_ff, rp_in;
   logic [63:0]         prev_ff, prev_in;
   logic [4:0]          lzc_ff, lzc_in;
   logic                first_ff, first_in;
   logic                ended_ff, ended_in;
   logic [2:0]          nrec_ff, nrec_in;

   logic [63:0]      win_ff, win_in;
   logic [6:0]       rsh_ff, rsh_in;
   logic [6:0]       lsh_ff, lsh_in;
   logic [CNT_W-1:0] need_ff, need_in;
   logic [4:0]       lznew_ff, lznew_in;

   logic        held_valid_ff, held_valid_in;
   logic [63:0] held_value_ff, held_value_in;
   logic        held_end_ff, held_end_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_end_ff, rsp_end_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             rd_vld_ff, rd_vld_in;

   logic             ram_we, ram_re;
   logic [H-1:0]     ram_waddr, ram_raddr;
   logic [63:0]      ram_wdata, ram_rdata;

   // header fields, always taken from the top of the buffer
   logic [1:0]  flag;
   logic [4:0]  lz3, lz1;
   logic [H-1:0] idx;
   logic [5:0]  sigf;
   logic [6:0]  sig, sum, tz;
   logic [CNT_W-1:0] dec_need;
   logic        out_free;
   logic [63:0] hist, xval, base, value;
   logic        is_end;
   logic        fits;
   logic [BUF_BITS-1:0] ext;

   chimpn_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign flag  = buf_ff[TOP -: 2];
   assign lz3   = lz_decode(buf_ff[TOP-2 -: 3]);
   assign idx   = buf_ff[TOP-2 -: H];
   assign lz1   = lz_decode(buf_ff[TOP-2-H -: 3]);
   assign sigf  = buf_ff[TOP-5-H -: 6];
   assign sig   = (sigf == 6'd0) ? 7'd64 : {1'b0, sigf};
   assign sum   = sig + {2'b00, lz1};
   assign tz    = (sum < 7'd64) ? (7'd64 - sum) : 7'd0;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hist     = rd_vld_ff ? ram_rdata : 64'd0;
   assign xval     = (win_ff >> rsh_ff) << lsh_ff;
   assign value    = base ^ xval;
   assign is_end   = (kind_ff != K_COPY) && (value == END_MARK);

   assign fits = ({1'b0, cnt_ff} + (CNT_W+1)'(WORD_BITS)) <= (CNT_W+1)'(BUF_BITS);
   assign ext  = {q_word, {(BUF_BITS-WORD_BITS){1'b0}}} >> cnt_ff;

   always_comb begin
      case (kind_ff)
         K_RAW:            base = 64'd0;
         K_REUSE, K_NEWLZ: base = prev_ff;
         default:          base = hist;
      endcase
   end

   always_comb begin
      kind_in  = K_RAW;
      dec_need = 9'd64;
      win_in   = buf_ff[TOP -: 64];
      rsh_in   = 7'd0;
      lsh_in   = 7'd0;
      lznew_in = lzc_ff;
      if (!first_ff) begin
         case (flag)
            FLAG_NEWLZ: begin
               kind_in  = K_NEWLZ;
               dec_need = CNT_W'(69) - CNT_W'(lz3);
               win_in   = buf_ff[TOP-5 -: 64];
               rsh_in   = {2'b00, lz3};
               lznew_in = lz3;
            end
            FLAG_REUSE: begin
               kind_in  = K_REUSE;
               dec_need = CNT_W'(66) - CNT_W'(lzc_ff);
               win_in   = buf_ff[TOP-2 -: 64];
               rsh_in   = {2'b00, lzc_ff};
            end
            FLAG_REF: begin
               kind_in  = K_REF;
               dec_need = CNT_W'(2 + H + 9) + CNT_W'(sig);
               win_in   = buf_ff[TOP-11-H -: 64];
               rsh_in   = 7'd64 - sig;
               lsh_in   = tz;
               lznew_in = lz1;
            end
            default: begin
               kind_in  = K_COPY;
               dec_need = CNT_W'(2 + H);
               win_in   = 64'd0;
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      buf_in        = buf_ff;
      cnt_in        = cnt_ff;
      rp_in         = rp_ff;
      prev_in       = prev_ff;
      lzc_in        = lzc_ff;
      first_in      = first_ff;
      ended_in      = ended_ff;
      nrec_in       = nrec_ff;
      need_in       = need_ff;
      held_valid_in = held_valid_ff;
      held_value_in = held_value_ff;
      held_end_in   = held_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_last_in   = rsp_last_ff;
      vld_in        = vld_ff;
      rd_vld_in     = rd_vld_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = rp_ff;
      ram_wdata     = value;
      ram_re        = 1'b0;
      ram_raddr     = idx;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!ended_ff) begin
                  if (fits) begin
                     buf_in = buf_ff | ext;
                     cnt_in = cnt_ff + CNT_W'(WORD_BITS);
                  end
                  nrec_in  = 3'd0;
                  state_in = S_HDR;
               end
            end
         end
         S_HDR: begin
            if (dec_need <= cnt_ff && nrec_ff < 3'(MAX_RECORDS)) begin
               need_in   = dec_need;
               ram_re    = 1'b1;
               rd_vld_in = vld_ff[idx];
               state_in  = S_EXEC;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_EXEC: begin
            if (!held_valid_ff || out_free) begin
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = held_value_ff;
                  rsp_end_in   = held_end_ff;
                  rsp_last_in  = 1'b0;
               end
               held_valid_in = 1'b1;
               buf_in  = buf_ff << need_ff;
               cnt_in  = cnt_ff - need_ff;
               nrec_in = nrec_ff + 3'd1;
               first_in = 1'b0;
               lzc_in  = lznew_ff;
               if (is_end) begin
                  held_value_in = 64'd0;
                  held_end_in   = 1'b1;
                  ended_in      = 1'b1;
                  state_in      = S_FLUSH;
               end else begin
                  held_value_in = value;
                  held_end_in   = 1'b0;
                  prev_in       = value;
                  ram_we        = 1'b1;
                  if (kind_ff != K_RAW) begin
                     rp_in     = rp_ff + 1'b1;
                     ram_waddr = rp_in;
                  end
                  vld_in[ram_waddr] = 1'b1;
                  state_in = S_HDR;
               end
            end
         end
         default: begin
            if (!held_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = held_value_ff;
               rsp_end_in    = held_end_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      win_ff        <= win_in;
      rsh_ff        <= rsh_in;
      lsh_ff        <= lsh_in;
      lznew_ff      <= lznew_in;
      need_ff       <= need_in;
      held_value_ff <= held_value_in;
      held_end_ff   <= held_end_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_last_ff   <= rsp_last_in;
      rd_vld_ff     <= rd_vld_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         buf_ff        <= '0;
         cnt_ff        <= '0;
         rp_ff         <= '0;
         prev_ff       <= '0;
         lzc_ff        <= '0;
         first_ff      <= 1'b1;
         ended_ff      <= 1'b0;
         nrec_ff       <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         vld_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         buf_ff        <= buf_in;
         cnt_ff        <= cnt_in;
         rp_ff         <= rp_in;
         prev_ff       <= prev_in;
         lzc_ff        <= lzc_in;
         first_ff      <= first_in;
         ended_ff      <= ended_in;
         nrec_ff       <= nrec_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         vld_ff        <= vld_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value_bits    = rsp_value_ff;
   assign rsp_end_of_stream = rsp_end_ff;
   assign rsp_last          = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> !ended_ff)
      else $error("record decoded after end of stream");

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(BUF_BITS))
      else $error("bit count beyond buffer size");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_end_ff) |-> (rsp_last_ff && rsp_value_ff == 64'd0))
      else $error("end marker result malformed");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !held_valid_ff)
      else $error("held result left behind at end of transaction");

endmodule

/* hw/rtl/chimpn_float_stream_decoder.sv */
`timescale 1ns / 1ps
// A word passes the queue, then load, header and execute; each result is then held until the
// next record executes or the flush step, so that its last flag is known before it goes out.
// The record loop (header decode, then history read and XOR) limits throughput, and a busy
// output stalls it; the core takes the next word only once it is back in idle. Reset
// (synchronous) clears buffer, history valid bits, ring position, previous value and
// leading-zero count; no clearing pass. Depends on chimpn_pkg, chimpn_word_queue, chimpn_decode_core.
module chimpn_float_stream_decoder import chimpn_pkg::*; #(
   parameter int HISTORY_LOG2 = HISTORY_LOG2_DEFAULT,
   parameter int WORD_BITS    = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_stream_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_value_bits,
   output logic                 rsp_end_of_stream,
   output logic                 rsp_last
);

   logic                 q_valid;
   logic                 q_pop;
   logic [WORD_BITS-1:0] q_word;

   // front end: words queue up here while the core works through records
   chimpn_word_queue #(.WORD_BITS(WORD_BITS)) u_queue (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_word (req_stream_word),
      .q_valid         (q_valid),
      .q_word          (q_word),
      .q_pop           (q_pop)
   );

   // back end: one word per transaction, up to six records each; a result is
   // held one record so that its last flag is known before it goes out
   chimpn_decode_core #(
      .HISTORY_LOG2 (HISTORY_LOG2),
      .WORD_BITS    (WORD_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_word            (q_word),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value_bits    (rsp_value_bits),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_last          (rsp_last)
   );

endmodule
